@@ rtl/lzd_pkg.sv @@
// Shared types, constants and codes for the LZ10 stream decompressor.
package lzd_pkg;

    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int CNT_W     = 32;
    localparam int RUN_W     = 5;

    localparam logic [7:0]       MAGIC_BYTE = 8'h10;
    localparam logic [RUN_W-1:0] LEN_BIAS   = 5'd3;
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

    // Result status codes.
    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_DIST      = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_EXCESS    = 3'd4;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_SIZE,
        PH_XSIZE,
        PH_BODY,
        PH_SECOND,
        PH_COPY,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [2:0] status;
        logic       run_last;
        logic       done;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } win_req_t;

endpackage

@@ rtl/lz10_stream_decompressor.sv @@
// Top level of the LZ10 stream decompressor: controller, window memory and output stage.
//
//  Channel  | Handshake           | Payload                                   | Direction
//  ---------+---------------------+-------------------------------------------+----------
//  input    | in_valid / in_ready | in_byte[7:0], in_last                     | into block
//  output   | out_valid/out_ready | out_byte[7:0], status[2:0], run_last,     | out of block
//           |                     | stream_done                               |
//
// Header, flag and first token bytes are taken back to back. A literal request is accepted
// into a pending register, then its result moves into the output register once it is free.
// A back-reference of length L occupies the block until its L bytes are emitted: the copy
// engine reads the history window (registered read) and emits one byte per cycle while the
// output register is free, so the single window read port sets the copy rate.
// Reset is asynchronous and active low; the window contents are not cleared, since a
// stream only ever reads bytes it has already written. No clearing pass is needed.
// A stalled output register holds its result and stops the copy engine; input is refused
// while a copy is running or while a result is still waiting to leave the controller.
module lz10_stream_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic       run_last,
    output logic       stream_done
);
    import lzd_pkg::*;

    result_t    result;
    win_req_t   win_req;
    logic [7:0] win_rdata;
    logic       out_free;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] status_reg;
    logic       run_last_reg;
    logic       done_reg;

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    lzd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .in_ready  (in_ready),
        .out_free  (out_free),
        .result    (result),
        .win_req   (win_req),
        .win_rdata (win_rdata)
    );

    lzd_window u_window (
        .clk   (clk),
        .req   (win_req),
        .rdata (win_rdata)
    );

    // Output register valid flag; the controller only presents a result when out_free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_byte_reg <= result.data;
            status_reg   <= result.status;
            run_last_reg <= result.run_last;
            done_reg     <= result.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign status      = status_reg;
    assign run_last    = run_last_reg;
    assign stream_done = done_reg;

endmodule

@@ rtl/lzd_window.sv @@
// History window memory: one write port and one registered read port.
module lzd_window (
    input  logic              clk,
    input  lzd_pkg::win_req_t req,
    output logic [7:0]        rdata
);
    import lzd_pkg::*;

    logic [7:0] mem [WIN_DEPTH];

    // Read returns the old contents on a same-address write; the controller forwards.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

@@ rtl/lzd_ctrl.sv @@
// Header and token parser, copy engine and counters of the decompressor.
module lzd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               in_ready,
    input  logic               out_free,
    output lzd_pkg::result_t   result,
    output lzd_pkg::win_req_t  win_req,
    input  logic [7:0]         win_rdata
);
    import lzd_pkg::*;

    phase_t            phase_reg,     phase_next;
    logic [1:0]        hdr_idx_reg,   hdr_idx_next;
    logic [CNT_W-1:0]  exp_reg,       exp_next;
    logic [CNT_W-1:0]  oc_reg,        oc_next;
    logic [CNT_W-1:0]  ic_reg,        ic_next;
    logic [CNT_W-1:0]  dic_reg,       dic_next;
    logic [7:0]        flags_reg,     flags_next;
    logic [3:0]        flag_pos_reg,  flag_pos_next;
    logic [7:0]        tok_reg,       tok_next;
    logic [WIN_AW-1:0] wp_reg,        wp_next;
    result_t           pend_reg,      pend_next;
    logic [RUN_W-1:0]  rd_left_reg,   rd_left_next;
    logic [RUN_W-1:0]  emit_left_reg, emit_left_next;
    logic [WIN_AW-1:0] rd_addr_reg,   rd_addr_next;
    logic              d_valid_reg,   d_valid_next;
    logic              fwd_reg,       fwd_next;
    logic [7:0]        fwd_data_reg,  fwd_data_next;
    logic              final_reg,     final_next;

    logic              accept;
    logic [CNT_W-1:0]  oc_inc;
    logic [CNT_W-1:0]  ic_inc;
    logic [3:0]        fp_m1;
    logic              flag_bit;
    logic              lit_we;
    logic              cp_emit;
    logic              cp_issue;
    logic [7:0]        d_byte;

    assign accept   = in_valid && in_ready;
    assign oc_inc   = (oc_reg == CNT_MAX) ? oc_reg : oc_reg + 1'b1;
    assign ic_inc   = (ic_reg == CNT_MAX) ? ic_reg : ic_reg + 1'b1;
    assign fp_m1    = flag_pos_reg - 4'd1;
    assign flag_bit = flags_reg[fp_m1[2:0]];
    assign lit_we   = accept && (phase_reg == PH_BODY) && (flag_pos_reg != 4'd0) && !flag_bit;
    assign cp_emit  = (phase_reg == PH_COPY) && d_valid_reg && out_free;
    assign cp_issue = (phase_reg == PH_COPY) && (rd_left_reg != '0) && (!d_valid_reg || out_free);
    assign d_byte   = fwd_reg ? fwd_data_reg : win_rdata;

    // Next state and datapath.
    always_comb
    begin
        logic [CNT_W-1:0] exp_acc;
        logic [12:0]      tok_dist;
        logic [RUN_W-1:0] len;
        logic [CNT_W:0]   oc_sum;
        logic [CNT_W:0]   limit;
        logic             fail;
        logic [2:0]       fail_st;
        logic             rearm;

        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        exp_next       = exp_reg;
        oc_next        = oc_reg;
        ic_next        = ic_reg;
        dic_next       = dic_reg;
        flags_next     = flags_reg;
        flag_pos_next  = flag_pos_reg;
        tok_next       = tok_reg;
        wp_next        = wp_reg;
        pend_next      = pend_reg;
        rd_left_next   = rd_left_reg;
        emit_left_next = emit_left_reg;
        rd_addr_next   = rd_addr_reg;
        d_valid_next   = d_valid_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        final_next     = final_reg;

        exp_acc  = exp_reg | ({24'd0, in_byte} << {hdr_idx_reg, 3'b000});
        tok_dist = {1'b0, tok_reg[3:0], in_byte} + 13'd1;
        len      = {1'b0, tok_reg[7:4]} + LEN_BIAS;
        oc_sum   = {1'b0, oc_reg} + {{(CNT_W + 1 - RUN_W){1'b0}}, len};
        limit    = {1'b0, dic_reg[CNT_W-1:2], 2'b00} + 33'd4;
        fail     = 1'b0;
        fail_st  = ST_DATA;
        rearm    = 1'b0;

        if (pend_reg.valid && out_free)
        begin
            pend_next.valid = 1'b0;
        end

        if (accept)
        begin
            ic_next = ic_inc;
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (in_byte != MAGIC_BYTE)
                    begin
                        fail    = 1'b1;
                        fail_st = ST_BAD_MAGIC;
                    end
                    else
                    begin
                        phase_next   = PH_SIZE;
                        hdr_idx_next = 2'd0;
                    end
                end
                PH_SIZE:
                begin
                    exp_next = exp_acc;
                    if (hdr_idx_reg == 2'd2)
                    begin
                        hdr_idx_next  = 2'd0;
                        flag_pos_next = 4'd0;
                        phase_next    = (exp_acc == '0) ? PH_XSIZE : PH_BODY;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 2'd1;
                    end
                end
                PH_XSIZE:
                begin
                    exp_next = exp_acc;
                    if (hdr_idx_reg == 2'd3)
                    begin
                        flag_pos_next = 4'd0;
                        if (exp_acc == '0)
                        begin
                            phase_next = PH_DONE;
                            dic_next   = ic_inc;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 2'd1;
                    end
                end
                PH_BODY:
                begin
                    if (flag_pos_reg == 4'd0)
                    begin
                        flags_next    = in_byte;
                        flag_pos_next = 4'd8;
                    end
                    else
                    begin
                        flag_pos_next = fp_m1;
                        if (flag_bit)
                        begin
                            tok_next   = in_byte;
                            phase_next = PH_SECOND;
                        end
                        else
                        begin
                            wp_next   = wp_reg + 1'b1;
                            oc_next   = oc_inc;
                            pend_next = '{valid: 1'b1, data: in_byte, status: ST_DATA,
                                          run_last: 1'b1, done: (oc_inc >= exp_reg)};
                            if (oc_inc >= exp_reg)
                            begin
                                phase_next = PH_DONE;
                                dic_next   = ic_inc;
                            end
                        end
                    end
                end
                PH_SECOND:
                begin
                    if ({19'd0, tok_dist} > oc_reg)
                    begin
                        fail    = 1'b1;
                        fail_st = ST_DIST;
                    end
                    else if (in_last && (oc_sum < {1'b0, exp_reg}))
                    begin
                        // The copy cannot complete the stream: drop it.
                        fail    = 1'b1;
                        fail_st = ST_SHORT;
                    end
                    else
                    begin
                        phase_next     = PH_COPY;
                        rd_left_next   = len;
                        emit_left_next = len;
                        rd_addr_next   = wp_reg - tok_dist[WIN_AW-1:0];
                        d_valid_next   = 1'b0;
                        fwd_next       = 1'b0;
                        final_next     = in_last;
                    end
                end
                PH_DONE:
                begin
                    if (in_last && (limit < {1'b0, ic_inc}))
                    begin
                        fail    = 1'b1;
                        fail_st = ST_EXCESS;
                    end
                end
                PH_COPY:
                begin
                    phase_next = phase_reg;
                end
                PH_ERROR:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase

            if (in_last && !fail)
            begin
                if (phase_reg == PH_ERROR || phase_next == PH_DONE)
                begin
                    rearm = 1'b1;
                end
                else if (phase_next != PH_COPY)
                begin
                    fail    = 1'b1;
                    fail_st = ST_SHORT;
                end
            end

            if (fail)
            begin
                pend_next = '{valid: 1'b1, data: 8'd0, status: fail_st,
                              run_last: 1'b1, done: (fail_st == ST_EXCESS)};
                if (in_last)
                begin
                    rearm = 1'b1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
        end

        if (cp_issue)
        begin
            rd_addr_next  = rd_addr_reg + 1'b1;
            rd_left_next  = rd_left_reg - 1'b1;
            d_valid_next  = 1'b1;
            fwd_next      = cp_emit && (rd_addr_reg == wp_reg);
            fwd_data_next = d_byte;
        end
        else if (cp_emit)
        begin
            d_valid_next = 1'b0;
        end

        if (cp_emit)
        begin
            wp_next        = wp_reg + 1'b1;
            oc_next        = oc_inc;
            emit_left_next = emit_left_reg - 1'b1;
            if (emit_left_reg == 5'd1)
            begin
                if (final_reg)
                begin
                    rearm = 1'b1;
                end
                else if (oc_inc >= exp_reg)
                begin
                    phase_next = PH_DONE;
                    dic_next   = ic_reg;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
        end

        if (rearm)
        begin
            phase_next    = PH_MAGIC;
            hdr_idx_next  = 2'd0;
            exp_next      = '0;
            oc_next       = '0;
            ic_next       = '0;
            dic_next      = '0;
            flags_next    = 8'd0;
            flag_pos_next = 4'd0;
            tok_next      = 8'd0;
            wp_next       = '0;
            final_next    = 1'b0;
        end
    end

    // Outputs toward the input channel, the output stage and the window.
    always_comb
    begin
        in_ready = (phase_reg != PH_COPY) && !pend_reg.valid;

        if (pend_reg.valid)
        begin
            result       = pend_reg;
            result.valid = out_free;
        end
        else
        begin
            result = '{valid: cp_emit, data: d_byte, status: ST_DATA,
                       run_last: (emit_left_reg == 5'd1), done: (oc_inc >= exp_reg)};
        end

        win_req = '{we: lit_we || cp_emit, waddr: wp_reg,
                    wdata: lit_we ? in_byte : d_byte,
                    re: cp_issue, raddr: rd_addr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            hdr_idx_reg   <= 2'd0;
            exp_reg       <= '0;
            oc_reg        <= '0;
            ic_reg        <= '0;
            dic_reg       <= '0;
            flags_reg     <= 8'd0;
            flag_pos_reg  <= 4'd0;
            tok_reg       <= 8'd0;
            wp_reg        <= '0;
            pend_reg      <= '0;
            rd_left_reg   <= '0;
            emit_left_reg <= '0;
            rd_addr_reg   <= '0;
            d_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            fwd_data_reg  <= 8'd0;
            final_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            exp_reg       <= exp_next;
            oc_reg        <= oc_next;
            ic_reg        <= ic_next;
            dic_reg       <= dic_next;
            flags_reg     <= flags_next;
            flag_pos_reg  <= flag_pos_next;
            tok_reg       <= tok_next;
            wp_reg        <= wp_next;
            pend_reg      <= pend_next;
            rd_left_reg   <= rd_left_next;
            emit_left_reg <= emit_left_next;
            rd_addr_reg   <= rd_addr_next;
            d_valid_reg   <= d_valid_next;
            fwd_reg       <= fwd_next;
            fwd_data_reg  <= fwd_data_next;
            final_reg     <= final_next;
        end
    end

endmodule

@@ tb/lz10_stream_decompressor_test.sv @@
// Self-checking testbench for the LZ10 stream decompressor with a built-in stream encoder.
`timescale 1ns / 100ps

module lz10_stream_decompressor_test;

    import lzd_pkg::*;

    // Stimulus shape. The receiver stall and the stretch without idling are keyed to the
    // number of requests the block has taken, so they land in the middle of the run.
    localparam int IDLE_PCT     = 17;
    localparam int REQ_TARGET   = 200;
    localparam int STALL_AT     = 70;
    localparam int STALL_CYCLES = 400;
    localparam int QUIET_FROM   = 120;
    localparam int QUIET_TO     = 175;
    localparam int DRAIN_CYCLES = 40;

    // One request on the input channel: a byte of the compressed stream.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_req_t;

    // One result on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] st;
        logic       run_last;
        logic       done;
    } byte_result_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       run_last;
    logic       stream_done;

    stream_req_t  req_backlog[$];
    byte_result_t due_results[$];
    byte_result_t step_q[$];

    int  reqs_queued   = 0;
    int  reqs_taken    = 0;
    int  streams_taken = 0;
    int  data_checked  = 0;
    int  errs_checked  = 0;
    int  mismatches    = 0;
    bit  req_taken     = 1'b0;
    logic quiet;

    // Receiver hold-off, owned by the receiver process.
    int  stall_left = 0;
    bit  stall_done = 1'b0;

    // Decoder state kept by the testbench.
    logic [7:0]  hist [WIN_DEPTH];
    logic [11:0] wr_pos;
    logic [31:0] out_cnt;
    logic [31:0] size_goal;
    logic [31:0] in_cnt;
    logic [31:0] done_in_cnt;
    phase_t      phase;
    logic [1:0]  hdr_idx;
    logic [7:0]  flags;
    logic [3:0]  flag_left;
    logic [7:0]  token_hi;
    bit          step_closed;

    lz10_stream_decompressor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .status      (status),
        .run_last    (run_last),
        .stream_done (stream_done)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Neither side idles while the block works through this window of requests.
    assign quiet = (reqs_taken >= QUIET_FROM) && (reqs_taken < QUIET_TO);

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // After any final byte the decoder waits for a fresh magic byte with all counters
    // cleared. The history window is left alone, as in the block.
    function automatic void rearm();
        wr_pos      = '0;
        out_cnt     = '0;
        size_goal   = '0;
        in_cnt      = '0;
        done_in_cnt = '0;
        phase       = PH_MAGIC;
        hdr_idx     = '0;
        flags       = '0;
        flag_left   = '0;
        token_hi    = '0;
    endfunction

    function automatic void queue_result(input logic [7:0] d, input logic [2:0] st,
                                         input logic dn);
        byte_result_t r;
        r.data     = d;
        r.st       = st;
        r.run_last = 1'b0;
        r.done     = dn;
        step_q.push_back(r);
    endfunction

    // An error replaces whatever data this request produced with a single report.
    // Unless the request is the final byte, the decoder then drops everything up to
    // the final byte.
    function automatic void abort_stream(input logic [2:0] st, input logic last);
        step_q.delete();
        queue_result(8'h00, st, st == ST_EXCESS);
        step_closed = 1'b1;
        if (last)
            rearm();
        else
            phase = PH_ERROR;
    endfunction

    function automatic void mark_done_if_met();
        if (out_cnt >= size_goal)
        begin
            phase       = PH_DONE;
            done_in_cnt = in_cnt;
        end
    endfunction

    function automatic void enter_body();
        phase     = PH_BODY;
        flag_left = '0;
        mark_done_if_met();
    endfunction

    function automatic void emit_byte(input logic [7:0] v);
        hist[wr_pos] = v;
        wr_pos++;
        if (out_cnt != CNT_MAX)
            out_cnt++;
        queue_result(v, ST_DATA, out_cnt >= size_goal);
    endfunction

    // Works out the results that one accepted request causes and appends them to the
    // queue of results still owed by the block.
    function automatic void decode_step(input logic [7:0] b, input logic last);
        logic [4:0]   run_len;
        logic [12:0]  back_dist;
        logic [11:0]  rd_pos;
        byte_result_t r;
        step_q.delete();
        step_closed = 1'b0;
        if (in_cnt != CNT_MAX)
            in_cnt++;
        case (phase)
            PH_MAGIC:
            begin
                if (b != MAGIC_BYTE)
                    abort_stream(ST_BAD_MAGIC, last);
                else
                begin
                    phase   = PH_SIZE;
                    hdr_idx = '0;
                end
            end
            PH_SIZE:
            begin
                size_goal |= 32'(b) << (8 * hdr_idx);
                if (hdr_idx != 2'd2)
                    hdr_idx++;
                else if (size_goal == '0)
                begin
                    // A zero 24-bit size means a 32-bit size follows.
                    phase   = PH_XSIZE;
                    hdr_idx = '0;
                end
                else
                    enter_body();
            end
            PH_XSIZE:
            begin
                size_goal |= 32'(b) << (8 * hdr_idx);
                if (hdr_idx != 2'd3)
                    hdr_idx++;
                else
                    enter_body();
            end
            PH_BODY:
            begin
                if (flag_left == '0)
                begin
                    flags     = b;
                    flag_left = 4'd8;
                end
                else
                begin
                    flag_left--;
                    if (flags[flag_left[2:0]])
                    begin
                        token_hi = b;
                        phase    = PH_SECOND;
                    end
                    else
                    begin
                        emit_byte(b);
                        mark_done_if_met();
                    end
                end
            end
            PH_SECOND:
            begin
                back_dist = {1'b0, token_hi[3:0], b} + 13'd1;
                if ({19'd0, back_dist} > out_cnt)
                    abort_stream(ST_DIST, last);
                else
                begin
                    // Byte-by-byte copy, so an overlapping run repeats its own output.
                    run_len = 5'(token_hi[7:4]) + LEN_BIAS;
                    rd_pos  = wr_pos - back_dist[11:0];
                    repeat (run_len)
                    begin
                        emit_byte(hist[rd_pos]);
                        rd_pos++;
                    end
                    phase = PH_BODY;
                    mark_done_if_met();
                end
            end
            PH_DONE:
            begin
                // Trailing bytes are padding. Only more than the 4-byte aligned amount
                // is reported, and only on the final byte.
                step_closed = 1'b1;
                if (last)
                begin
                    if (({1'b0, done_in_cnt[31:2], 2'b00} + 33'd4) < {1'b0, in_cnt})
                        abort_stream(ST_EXCESS, 1'b1);
                    else
                        rearm();
                end
            end
            default:
            begin
                phase       = PH_ERROR;
                step_closed = 1'b1;
                if (last)
                    rearm();
            end
        endcase
        if (!step_closed && last)
        begin
            if (phase != PH_DONE)
                abort_stream(ST_SHORT, 1'b1);
            else
                rearm();
        end
        foreach (step_q[i])
        begin
            r          = step_q[i];
            r.run_last = (i == step_q.size() - 1);
            due_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic void push_req(input logic [7:0] b, input logic last);
        stream_req_t r;
        r.data = b;
        r.last = last;
        req_backlog.push_back(r);
        reqs_queued++;
    endfunction

    // Encodes a stream that decompresses to about goal bytes with random literals and
    // back-references, under a header that announces declared bytes. The two need not
    // agree, which gives streams that end early or finish before their last token.
    // pad appends trailing bytes, keep (when nonzero) cuts the stream to that length,
    // and far_ref makes the first back-reference reach past the start of the output.
    function automatic void add_stream(input logic [31:0] declared, input int goal,
                                       input bit ext, input int pad, input int keep,
                                       input bit far_ref);
        logic [7:0]  enc[$];
        logic [7:0]  flag_byte;
        logic [11:0] dm1;
        int          made;
        int          flag_at;
        int          k;
        int          len;
        int          span;
        bit          stop;
        enc.push_back(MAGIC_BYTE);
        if (ext)
            repeat (3) enc.push_back(8'h00);
        for (k = 0; k < (ext ? 4 : 3); k++)
            enc.push_back(declared[8*k +: 8]);
        made = 0;
        stop = 1'b0;
        while (made < goal && !stop)
        begin
            // Flag bits past the end of the stream are left random.
            flag_at   = enc.size();
            flag_byte = 8'($urandom);
            enc.push_back(8'h00);
            for (k = 7; k >= 0 && made < goal && !stop; k--)
            begin
                if (made > 0 && (far_ref || $urandom_range(99) < 45))
                begin
                    span = (made > WIN_DEPTH) ? WIN_DEPTH : made;
                    len  = $urandom_range(18, 3);
                    if (far_ref)
                    begin
                        dm1  = 12'($urandom_range(WIN_DEPTH, made + 1) - 1);
                        stop = 1'b1;
                    end
                    else
                        dm1 = 12'($urandom_range(span, 1) - 1);
                    flag_byte[k] = 1'b1;
                    enc.push_back({4'(len - 3), dm1[11:8]});
                    enc.push_back(dm1[7:0]);
                    made += len;
                end
                else
                begin
                    flag_byte[k] = 1'b0;
                    enc.push_back(8'($urandom));
                    made++;
                end
            end
            enc[flag_at] = flag_byte;
        end
        repeat (pad) enc.push_back(8'($urandom));
        if (keep > 0)
            while (enc.size() > keep)
                enc.delete(enc.size() - 1);
        foreach (enc[i])
            push_req(enc[i], i == enc.size() - 1);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers the backlog one request at a time, changing inputs on the
    // falling edge. A request that is offered stays put until it is taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : sender
        stream_req_t nxt;
        bit          offer;
        if (rst_n && (!in_valid || req_taken))
        begin
            offer = (req_backlog.size() != 0) &&
                    (quiet || $urandom_range(99) >= IDLE_PCT);
            if (offer)
            begin
                nxt = req_backlog.pop_front();
                in_byte <= nxt.data;
                in_last <= nxt.last;
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off part way through the
    // run so that the block fills up and has to refuse requests.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!stall_done && reqs_taken >= STALL_AT)
            begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes are sampled on the rising edge. Each taken request
    // feeds the decoder model, and each result leaving the block is checked against
    // the oldest result still owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        byte_result_t want;
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            req_taken = in_valid && in_ready;
            if (req_taken)
            begin
                decode_step(in_byte, in_last);
                reqs_taken++;
                if (in_last)
                    streams_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h status %0d", out_byte, status);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.st == ST_DATA)
                        data_checked++;
                    else
                        errs_checked++;
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
                        mismatches++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        mismatches++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b", want.run_last, run_last);
                        mismatches++;
                    end
                    if (stream_done !== want.done)
                    begin
                        $error("stream_done: expected %0b, actual %0b", want.done,
                               stream_done);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int         pick;
        int         goal;
        int         n;
        int         k;
        logic [7:0] b;

        for (k = 0; k < WIN_DEPTH; k++)
            hist[k] = 8'h00;
        rearm();

        // Smallest stream: an all-zero flag byte and one literal of all ones.
        push_req(MAGIC_BYTE, 1'b0);
        push_req(8'h01, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b1);
        // Wrong magic on the final byte.
        push_req(8'hFF, 1'b1);
        // Wrong magic, then a final byte that is swallowed by the latched error.
        push_req(8'h00, 1'b0);
        push_req(MAGIC_BYTE, 1'b1);
        // A back-reference before any output exists is too far; it is also the final byte.
        push_req(MAGIC_BYTE, 1'b0);
        push_req(8'h03, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h00, 1'b1);
        // One literal, then an 18-byte copy at distance one, then more padding than the
        // aligned allowance, which gives an excess-input report.
        push_req(MAGIC_BYTE, 1'b0);
        push_req(8'h13, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h40, 1'b0);
        push_req(8'hAB, 1'b0);
        push_req(8'hF0, 1'b0);
        push_req(8'h00, 1'b0);
        repeat (4) push_req(8'h5A, 1'b0);
        push_req(8'hA5, 1'b1);

        // Random streams, mostly well formed; most are short with an occasional long one.
        while (reqs_queued < REQ_TARGET)
        begin
            pick = $urandom_range(99);
            goal = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
            if (pick < 58)
                add_stream(goal, goal, $urandom_range(4) == 0, $urandom_range(7), 0, 1'b0);
            else if (pick < 68)
                add_stream(goal, goal, $urandom_range(1), 0, $urandom_range(goal + 8, 1),
                           1'b0);
            else if (pick < 74)
                add_stream($urandom, goal, 1'b1, $urandom_range(3), 0, 1'b0);
            else if (pick < 80)
                add_stream($urandom_range(goal, 1), goal, 1'b0, $urandom_range(7), 0, 1'b0);
            else if (pick < 87)
                add_stream(goal, goal, 1'b0, $urandom_range(3), 0, 1'b1);
            else if (pick < 94)
            begin
                do
                    b = 8'($urandom);
                while (b == MAGIC_BYTE);
                n = $urandom_range(3);
                push_req(b, n == 0);
                for (k = 1; k <= n; k++)
                    push_req(8'($urandom), k == n);
            end
            else
                add_stream(0, 0, 1'b1, $urandom_range(7), 0, 1'b0);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        // Anything the block still emits now is caught as unexpected by the monitor.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests in %0d streams, with one %0d-cycle output stall.",
                 reqs_taken, streams_taken, STALL_CYCLES);
        $display("Checked %0d data bytes and %0d error reports, %0d mismatches.",
                 data_checked, errs_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still owed.", due_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lzd_pkg.sv
rtl/lzd_window.sv
rtl/lzd_ctrl.sv
rtl/lz10_stream_decompressor.sv
tb/lz10_stream_decompressor_test.sv
